FILE: src/assert_macros.svh
// assertion helpers, empty when synthesized
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/mh2_pkg.sv
`default_nettype none

package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5BD1_E995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KMIX1,
        S_KMIX2,
        S_HMIX,
        S_TAIL,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: src/mh2_if.sv
`default_nettype none

interface mh2_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] msg_length;
    logic        last_byte;
    logic        empty_message;

    modport source (output valid, output data_byte, output msg_length,
                    output last_byte, output empty_message, input ready);
    modport sink   (input valid, input data_byte, input msg_length,
                    input last_byte, input empty_message, output ready);
endinterface

interface mh2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

FILE: src/murmur_hash2_32.sv
// murmur_hash2_32: streaming 32-bit MurmurHash2, seed zero, one byte per transfer
// i_in carries data_byte, msg_length (taken on the first byte of a message),
// last_byte and empty_message; o_out carries hash_value, one per message.
// bytes 1..3 of each word are packed into a pending register. the fourth byte starts the
// word mix: three steps on the one shared 32x32 multiplier (k*m, k*m, h*m).
// on the last byte a partial tail takes one multiply step, then the
// finalizer takes one more and loads the output register.
// an empty-message transfer loads hash 0 into the output register at once.
// i_in.ready is high only while the sequencer is idle and the output
// register is free or being emptied in the same cycle.
// when the receiver stalls, the hash waits in the output register and the
// finalizer step holds until it drains.
// reset (synchronous, active low) returns to idle with no message open and
// no result pending.
`default_nettype none

`include "assert_macros.svh"

module murmur_hash2_32
    import mh2_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    mh2_in_if.sink     i_in,
    mh2_out_if.source  o_out
);

    t_state      r_state, n_state;
    logic [31:0] r_h, n_h;
    logic [31:0] r_k, n_k;
    logic [23:0] r_pend, n_pend;
    logic [1:0]  r_phase, n_phase;
    logic        r_in_msg, n_in_msg;
    logic        r_last, n_last;
    logic [31:0] r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic        out_free;
    logic        in_rdy;
    logic        in_xfer;
    logic        empty_xfer;
    logic [31:0] h_start;
    logic [1:0]  ph_start;

    assign mul_p      = 32'(mul_a * MIX_MUL);
    assign out_free   = !r_out_valid || o_out.ready;
    assign in_rdy     = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in.valid && in_rdy;
    assign empty_xfer = in_xfer && i_in.empty_message;
    assign h_start    = r_in_msg ? r_h : i_in.msg_length;
    assign ph_start   = r_in_msg ? r_phase : 2'd0;

    assign i_in.ready       = in_rdy;
    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 2'd0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_in_msg    <= n_in_msg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_k    <= n_k;
        r_pend <= n_pend;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_k         = r_k;
        n_pend      = r_pend;
        n_phase     = r_phase;
        n_in_msg    = r_in_msg;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        mul_a       = r_h;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.empty_message) begin
                        n_out       = '0;
                        n_out_valid = 1'b1;
                        n_in_msg    = 1'b0;
                        n_phase     = 2'd0;
                    end else begin
                        n_h      = h_start;
                        n_in_msg = 1'b1;
                        n_last   = i_in.last_byte;
                        unique case (ph_start)
                            2'd0: begin
                                n_pend  = {16'h0000, i_in.data_byte};
                                n_phase = 2'd1;
                            end
                            2'd1: begin
                                n_pend  = {8'h00, i_in.data_byte, r_pend[7:0]};
                                n_phase = 2'd2;
                            end
                            2'd2: begin
                                n_pend  = {i_in.data_byte, r_pend[15:0]};
                                n_phase = 2'd3;
                            end
                            default: begin
                                n_k     = {i_in.data_byte, r_pend};
                                n_phase = 2'd0;
                                n_state = S_KMIX1;
                            end
                        endcase
                        if (ph_start != 2'd3 && i_in.last_byte) begin
                            n_state = S_TAIL;
                        end
                    end
                end
            end
            S_KMIX1: begin
                mul_a   = r_k;
                n_k     = mul_p;
                n_state = S_KMIX2;
            end
            S_KMIX2: begin
                mul_a   = r_k ^ (r_k >> MIX_SHIFT);
                n_k     = mul_p;
                n_state = S_HMIX;
            end
            S_HMIX: begin
                mul_a   = r_h;
                n_h     = mul_p ^ r_k;
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_TAIL: begin
                mul_a   = r_h ^ {8'h00, r_pend};
                n_h     = mul_p;
                n_state = S_FIN;
            end
            S_FIN: begin
                mul_a = r_h ^ (r_h >> FIN_SHIFT_A);
                if (out_free) begin
                    n_out       = mul_p ^ (mul_p >> FIN_SHIFT_B);
                    n_out_valid = 1'b1;
                    n_in_msg    = 1'b0;
                    n_phase     = 2'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_ready_only_idle, i_clk, i_rst_n, i_in.ready, r_state == S_IDLE)
    `ASSERT_NEXT(a_empty_gives_zero, i_clk, i_rst_n, empty_xfer, r_out_valid && r_out == 32'h0)
    `ASSERT_IMPLIES(a_phase_needs_msg, i_clk, i_rst_n, r_phase != 2'd0, r_in_msg)
    `ASSERT_NEXT(a_kmix_order, i_clk, i_rst_n, r_state == S_KMIX1, r_state == S_KMIX2)

endmodule

`default_nettype wire

FILE: tb/murmur_hash2_32_tb.sv
`timescale 1ns / 100ps

module murmur_hash2_32_tb;
    import mh2_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int N_DIRECTED    = 25;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] msg_length;
        logic        last_byte;
        logic        empty_message;
    } t_msg_item;

    typedef struct packed {
        t_msg_item   item;
        logic        known;
        logic [31:0] hash_value;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    // known = 1 rows carry the hash typed in, the rest go through the predictor
    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        // empty message right after reset
        '{'{8'hA5, 32'h0000_0007, 1'b0, 1'b1}, 1'b1, 32'h0000_0000},
        // one-byte messages with zero and all-ones stated length
        '{'{8'h00, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, 32'h0},
        '{'{8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b0, 32'h0},
        // two byte tail, later length ignored
        '{'{8'h12, 32'h0000_0002, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h34, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b0, 32'h0},
        // three byte tail
        '{'{8'hFF, 32'h0000_0003, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h00, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h80, 32'h1234_5678, 1'b1, 1'b0}, 1'b0, 32'h0},
        // full word, no tail
        '{'{8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'hFF, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'hFF, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'hFF, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, 32'h0},
        // word plus one byte tail
        '{'{8'h01, 32'h0000_0005, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h02, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h03, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h04, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h05, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, 32'h0},
        // open message abandoned by an empty message with every field high
        '{'{8'hAA, 32'h0000_0009, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h55, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, 32'h0000_0000},
        // stated length differs from bytes delivered
        '{'{8'h5A, 32'h0000_000A, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'hC3, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, 32'h0},
        '{'{8'h00, 32'h0000_0000, 1'b0, 1'b1}, 1'b1, 32'h0000_0000},
        '{'{8'h7F, 32'h8000_0000, 1'b1, 1'b0}, 1'b0, 32'h0},
        '{'{8'h80, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, 32'h0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mh2_in_if  in_ch ();
    mh2_out_if out_ch ();

    murmur_hash2_32 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // running hash state
    logic [31:0] run_hash   = '0;
    logic [23:0] word_bytes = '0;
    logic [1:0]  word_fill  = '0;
    logic        msg_open   = 1'b0;

    logic [31:0] hash_q [$];
    logic [31:0] want_hash;
    int          fail_count  = 0;
    int          burst_left  = 0;
    logic [31:0] rx_cycle    = '0;
    t_rx_mode    rx_mode     = RX_ALWAYS;

    function automatic logic [31:0] finalize_hash(input logic [31:0] h);
        h = h ^ (h >> FIN_SHIFT_A);
        h = h * MIX_MUL;
        h = h ^ (h >> FIN_SHIFT_B);
        return h;
    endfunction

    // returns 1 when the transfer completes a message
    function automatic logic advance_hash(input t_msg_item it, output logic [31:0] done_hash);
        logic [31:0] k;
        logic [31:0] h;
        done_hash = '0;
        if (it.empty_message) begin
            run_hash   = '0;
            word_bytes = '0;
            word_fill  = '0;
            msg_open   = 1'b0;
            done_hash  = finalize_hash(32'h0);
            return 1'b1;
        end
        if (!msg_open) begin
            run_hash   = it.msg_length;
            word_bytes = '0;
            word_fill  = '0;
            msg_open   = 1'b1;
        end
        if (word_fill != 2'd3) begin
            word_bytes[word_fill*8 +: 8] = it.data_byte;
            word_fill = word_fill + 2'd1;
        end else begin
            k = {it.data_byte, word_bytes};
            k = k * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            run_hash   = (run_hash * MIX_MUL) ^ k;
            word_bytes = '0;
            word_fill  = '0;
        end
        if (!it.last_byte)
            return 1'b0;
        h = run_hash;
        if (word_fill != 2'd0) begin
            h = h ^ {8'h00, word_bytes};
            h = h * MIX_MUL;
        end
        done_hash  = finalize_hash(h);
        run_hash   = '0;
        word_bytes = '0;
        word_fill  = '0;
        msg_open   = 1'b0;
        return 1'b1;
    endfunction

    task automatic flag_fail(input string what, input logic [31:0] want,
                             input logic [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s: expected %08h, got %08h", what, want, got);
    endtask

    task automatic send_item(input t_msg_item it, input logic known,
                             input logic [31:0] typed_hash);
        int          gap;
        int          r;
        logic        produced;
        logic [31:0] h;
        if (burst_left == 0) begin
            r = $urandom_range(0, 9);
            if (r < 3)
                gap = 0;
            else if (r < 8)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(8, 20);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= it.data_byte;
        in_ch.msg_length    <= it.msg_length;
        in_ch.last_byte     <= it.last_byte;
        in_ch.empty_message <= it.empty_message;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        produced = advance_hash(it, h);
        if (produced)
            hash_q.push_back(known ? typed_hash : h);
    endtask

    // receiver stall pattern and result check
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 32'd1;
        if (rx_cycle[7:0] == 8'd0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:   out_ch.ready <= 1'b1;
            RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: out_ch.ready <= (rx_cycle % 5) != 0;
            default:     out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (hash_q.size() == 0) begin
                flag_fail("unexpected hash", 32'h0, out_ch.hash_value);
            end else begin
                want_hash = hash_q.pop_front();
                if (out_ch.hash_value !== want_hash)
                    flag_fail("wrong hash", want_hash, out_ch.hash_value);
            end
        end
    end

    initial begin
        t_msg_item   it;
        int          random_sent;
        int          pick;
        int          n_bytes;
        int          cut_at;
        int          drain;
        logic [31:0] stated;

        random_sent = 0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.msg_length    <= '0;
        in_ch.last_byte     <= 1'b0;
        in_ch.empty_message <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].known,
                      DIRECTED_ROWS[r].hash_value);

        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // lone empty message with random other fields
                it.data_byte     = 8'($urandom_range(0, 255));
                it.msg_length    = $urandom;
                it.last_byte     = 1'($urandom_range(0, 1));
                it.empty_message = 1'b1;
                send_item(it, 1'b0, 32'h0);
                random_sent++;
            end else begin
                n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    stated = n_bytes;
                else if (pick == 8)
                    stated = $urandom;
                else
                    stated = n_bytes ^ $urandom_range(1, 7);
                cut_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, n_bytes) : 0;
                for (int i = 0; i < n_bytes; i++) begin
                    if (cut_at != 0 && i == cut_at)
                        break;
                    it.data_byte     = 8'($urandom_range(0, 255));
                    it.msg_length    = (i == 0) ? stated : $urandom;
                    it.last_byte     = (i == n_bytes - 1) && (cut_at == 0);
                    it.empty_message = 1'b0;
                    send_item(it, 1'b0, 32'h0);
                    random_sent++;
                end
                if (cut_at != 0) begin
                    // broken message, dropped by an empty message
                    it.data_byte     = 8'($urandom_range(0, 255));
                    it.msg_length    = $urandom;
                    it.last_byte     = 1'($urandom_range(0, 1));
                    it.empty_message = 1'b1;
                    send_item(it, 1'b0, 32'h0);
                    random_sent++;
                end
            end
        end
        in_ch.valid <= 1'b0;

        drain = 0;
        while (hash_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (hash_q.size() != 0) begin
            fail_count += hash_q.size();
            $display("%0d hashes never arrived", hash_q.size());
        end

        if (fail_count == 0)
            $display("murmur_hash2_32: match");
        else
            $display("murmur_hash2_32: mismatch");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("murmur_hash2_32: mismatch");
        $finish;
    end

endmodule
